// File: src/bis_pkg.sv
// bilinear image scaler package: register indexes and shared types
// no dependencies
package bis_pkg;
	localparam int REG_SRC_WIDTH  = 0;
	localparam int REG_SRC_HEIGHT = 1;
	localparam int REG_INV_ROWS   = 2;
	localparam int REG_INV_COLS   = 3;
	localparam int REG_COLOR_MODE = 4;
	localparam int PADDR_W        = 5;

	typedef logic [7:0] chan_t;
endpackage

// File: src/bilinear_image_scaler.sv
// bilinear_image_scaler: 2x2 banked frame store with a bilinear blend pipeline
// a compute item's result strobe is the valid register of the last pipeline stage
// throughput: one item per cycle, busy stays low; the receiver cannot stall
// a store item writes one bank entry per cycle when row and col lie inside the frame store, and gives no result
// reset sets the config registers to their defaults and clears pipeline valids only, the frame store is undefined
// depends on bis_pkg
module bilinear_image_scaler #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic [12:0]                  row,
	input  logic [12:0]                  col,
	input  bis_pkg::chan_t               pix_b,
	input  bis_pkg::chan_t               pix_g,
	input  bis_pkg::chan_t               pix_r,
	output logic                         done,
	output bis_pkg::chan_t               out_b,
	output bis_pkg::chan_t               out_g,
	output bis_pkg::chan_t               out_r,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bis_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import bis_pkg::*;

	localparam int WB = $clog2(MAX_WIDTH);
	localparam int HB = $clog2(MAX_HEIGHT);
	localparam int WB2 = (WB > 1) ? WB - 1 : 1;
	localparam int HB2 = (HB > 1) ? HB - 1 : 1;
	localparam int BW = (MAX_WIDTH + 1) / 2;
	localparam int BH = (MAX_HEIGHT + 1) / 2;
	localparam int BADDR = HB2 + WB2;
	localparam int DEPTH = BW * BH;
	localparam int T_W = 35;
	localparam int UP = (FRAC_BITS > 17) ? FRAC_BITS - 17 : 0;
	localparam int DN = (FRAC_BITS < 17) ? 17 - FRAC_BITS : 0;
	localparam int P_W = T_W + UP;
	localparam int F1 = FRAC_BITS + 1;
	localparam int WT_W = 2 * FRAC_BITS + 2;
	localparam int ACC_W = WT_W + 10;
	localparam logic [F1-1:0] ONE = F1'(1) << FRAC_BITS;

	logic [9:0]  src_width_q, src_height_q;
	logic [20:0] inv_rows_q, inv_cols_q;
	logic        color_mode_q;

	assign pready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 10'd512;
			src_height_q <= 10'd512;
			inv_rows_q   <= 21'd65536;
			inv_cols_q   <= 21'd65536;
			color_mode_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (32'(paddr[PADDR_W-1:2]))
				REG_SRC_WIDTH:  src_width_q  <= pwdata[9:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[9:0];
				REG_INV_ROWS:   inv_rows_q   <= pwdata[20:0];
				REG_INV_COLS:   inv_cols_q   <= pwdata[20:0];
				REG_COLOR_MODE: color_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (32'(paddr[PADDR_W-1:2]))
			REG_SRC_WIDTH:  prdata = {22'd0, src_width_q};
			REG_SRC_HEIGHT: prdata = {22'd0, src_height_q};
			REG_INV_ROWS:   prdata = {11'd0, inv_rows_q};
			REG_INV_COLS:   prdata = {11'd0, inv_cols_q};
			REG_COLOR_MODE: prdata = {31'd0, color_mode_q};
			default:        prdata = '0;
		endcase
	end

	// saturated image sizes, minus one
	logic [12:0] wlast, hlast;
	always_comb begin
		if (src_width_q == 10'd0) wlast = '0;
		else if (13'(src_width_q) > 13'(MAX_WIDTH)) wlast = 13'(MAX_WIDTH - 1);
		else wlast = 13'(src_width_q) - 13'd1;
		if (src_height_q == 10'd0) hlast = '0;
		else if (13'(src_height_q) > 13'(MAX_HEIGHT)) hlast = 13'(MAX_HEIGHT - 1);
		else hlast = 13'(src_height_q) - 13'd1;
	end

	// stage 1: multiply (2d+1)*inv
	logic        v_s1, f_s1;
	logic [T_W-1:0] tr_s1, tc_s1;
	logic [12:0] wr_s1, wc_s1;
	logic [23:0] wp_s1;
	logic        wok_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		f_s1   <= func;
		tr_s1  <= T_W'({row, 1'b1}) * T_W'(inv_rows_q);
		tc_s1  <= T_W'({col, 1'b1}) * T_W'(inv_cols_q);
		wr_s1  <= row;
		wc_s1  <= col;
		wp_s1  <= {pix_r, pix_g, pix_b};
		wok_s1 <= (32'(row) < MAX_HEIGHT) && (32'(col) < MAX_WIDTH);
	end

	// stage 2: subtract half, rescale, clamp, split
	function automatic logic [P_W-1:0] map_pos(logic [T_W-1:0] t, logic [12:0] last);
		logic [T_W-1:0] u;
		logic [P_W-1:0] p, lim;
		u = (t > T_W'(65536)) ? t - T_W'(65536) : '0;
		p = (P_W'(u) << UP) >> DN;
		lim = P_W'(last) << FRAC_BITS;
		return (p > lim) ? lim : p;
	endfunction

	logic [P_W-1:0] pr, pc;
	assign pr = map_pos(tr_s1, hlast);
	assign pc = map_pos(tc_s1, wlast);

	logic        v_s2, f_s2;
	logic [12:0] r1_s2, c1_s2;
	logic [FRAC_BITS-1:0] fu_s2, fv_s2;
	logic [12:0] wr_s2, wc_s2;
	logic [23:0] wp_s2;
	logic        wok_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		f_s2  <= f_s1;
		r1_s2 <= 13'(pr >> FRAC_BITS);
		c1_s2 <= 13'(pc >> FRAC_BITS);
		fu_s2 <= pr[FRAC_BITS-1:0];
		fv_s2 <= pc[FRAC_BITS-1:0];
		wr_s2 <= wr_s1;
		wc_s2 <= wc_s1;
		wp_s2 <= wp_s1;
		wok_s2 <= wok_s1;
	end

	// bank addressing: bank (row parity, col parity), entry (row/2, col/2)
	logic [12:0] r2, c2;
	assign r2 = r1_s2 + 13'(fu_s2 != '0);
	assign c2 = c1_s2 + 13'(fv_s2 != '0);

	logic [HB2-1:0] ra [2];
	logic [WB2-1:0] ca [2];
	always_comb begin
		// even row/col index is whichever of the pair is even
		ra[0] = r1_s2[0] ? HB2'(r2 >> 1) : HB2'(r1_s2 >> 1);
		ra[1] = r1_s2[0] ? HB2'(r1_s2 >> 1) : HB2'(r2 >> 1);
		ca[0] = c1_s2[0] ? WB2'(c2 >> 1) : WB2'(c1_s2 >> 1);
		ca[1] = c1_s2[0] ? WB2'(c1_s2 >> 1) : WB2'(c2 >> 1);
	end

	logic [23:0] bank0 [DEPTH];
	logic [23:0] bank1 [DEPTH];
	logic [23:0] bank2 [DEPTH];
	logic [23:0] bank3 [DEPTH];
	logic [23:0] rd_s3 [4];

	logic [BADDR-1:0] waddr;
	logic [1:0] wbank;
	assign waddr = BADDR'(32'(wr_s2 >> 1) * BW + 32'(wc_s2 >> 1));
	assign wbank = {wr_s2[0], wc_s2[0]};
	logic wen;
	assign wen = v_s2 && !f_s2 && wok_s2;

	function automatic logic [BADDR-1:0] baddr(logic [HB2-1:0] r, logic [WB2-1:0] c);
		return BADDR'(32'(r) * BW + 32'(c));
	endfunction

	always_ff @(posedge clk) begin
		if (wen && wbank == 2'd0) bank0[waddr] <= wp_s2;
		rd_s3[0] <= bank0[baddr(ra[0], ca[0])];
	end
	always_ff @(posedge clk) begin
		if (wen && wbank == 2'd1) bank1[waddr] <= wp_s2;
		rd_s3[1] <= bank1[baddr(ra[0], ca[1])];
	end
	always_ff @(posedge clk) begin
		if (wen && wbank == 2'd2) bank2[waddr] <= wp_s2;
		rd_s3[2] <= bank2[baddr(ra[1], ca[0])];
	end
	always_ff @(posedge clk) begin
		if (wen && wbank == 2'd3) bank3[waddr] <= wp_s2;
		rd_s3[3] <= bank3[baddr(ra[1], ca[1])];
	end

	// stage 3: weights alongside the memory read
	logic v_s3, rp_s3, cp_s3, zu_s3, zv_s3;
	logic [WT_W-1:0] wa_s3, wb_s3, wc_s3, wd_s3;
	logic [F1-1:0] fu1, fv1, gu1, gv1;
	assign fu1 = F1'(fu_s2);
	assign fv1 = F1'(fv_s2);
	assign gu1 = ONE - fu1;
	assign gv1 = ONE - fv1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2 && f_s2;
	end
	always_ff @(posedge clk) begin
		rp_s3 <= r1_s2[0];
		cp_s3 <= c1_s2[0];
		zu_s3 <= (fu_s2 == '0);
		zv_s3 <= (fv_s2 == '0);
		wa_s3 <= WT_W'(gu1) * WT_W'(gv1);
		wb_s3 <= WT_W'(gu1) * WT_W'(fv1);
		wc_s3 <= WT_W'(fu1) * WT_W'(gv1);
		wd_s3 <= WT_W'(fu1) * WT_W'(fv1);
	end

	// route banks back to neighbour order; with a zero fraction the second
	// neighbour is the first one, the other bank holds an unrelated entry
	logic [23:0] p11, p12, p21, p22;
	always_comb begin
		p11 = rd_s3[{rp_s3, cp_s3}];
		p12 = zv_s3 ? p11 : rd_s3[{rp_s3, ~cp_s3}];
		p21 = zu_s3 ? p11 : rd_s3[{~rp_s3, cp_s3}];
		p22 = zu_s3 ? p12 : (zv_s3 ? p21 : rd_s3[{~rp_s3, ~cp_s3}]);
	end

	// stage 4: products
	logic v_s4;
	logic [ACC_W-1:0] pa_s4 [3], pb_s4 [3], pc_s4 [3], pd_s4 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			pa_s4[ch] <= ACC_W'(wa_s3) * ACC_W'(p11[ch*8 +: 8]);
			pb_s4[ch] <= ACC_W'(wb_s3) * ACC_W'(p12[ch*8 +: 8]);
			pc_s4[ch] <= ACC_W'(wc_s3) * ACC_W'(p21[ch*8 +: 8]);
			pd_s4[ch] <= ACC_W'(wd_s3) * ACC_W'(p22[ch*8 +: 8]);
		end
	end

	// stage 5: sum and truncate
	logic v_s5;
	chan_t res_s5 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			res_s5[ch] <= 8'((pa_s4[ch] + pb_s4[ch] + pc_s4[ch] + pd_s4[ch])
				>> (2 * FRAC_BITS));
		end
	end

	assign done  = v_s5;
	assign out_b = res_s5[0];
	assign out_g = color_mode_q ? res_s5[1] : 8'd0;
	assign out_r = color_mode_q ? res_s5[2] : 8'd0;
endmodule

// File: dv/bilinear_image_scaler_tb.sv
// testbench for bilinear_image_scaler: fills the frame store over the image area, then mixes
// stores and destination-pixel computes checked against a scoreboard predictor
// depends on bis_pkg and the bilinear_image_scaler rtl
module bilinear_image_scaler_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bis_pkg::*;

	typedef struct {
		chan_t b;
		chan_t g;
		chan_t r;
	} pixel_t;

	class scaler_scoreboard;
		bit [23:0]       frame[512*512];
		longint unsigned width_reg, height_reg, inv_rows, inv_cols, color;
		pixel_t          pixel_q[$];
		int              fails;
		int              computes;

		function new();
			width_reg = 512; height_reg = 512;
			inv_rows = 65536; inv_cols = 65536; color = 1;
			fails = 0; computes = 0;
		endfunction

		function void set_reg(int idx, logic [31:0] v);
			case (idx)
				REG_SRC_WIDTH:  width_reg = v & 32'h3ff;
				REG_SRC_HEIGHT: height_reg = v & 32'h3ff;
				REG_INV_ROWS:   inv_rows = v & 32'h1fffff;
				REG_INV_COLS:   inv_cols = v & 32'h1fffff;
				REG_COLOR_MODE: color = v & 1;
				default: ;
			endcase
		endfunction

		function longint unsigned sat_size(longint unsigned v);
			if (v < 1) return 1;
			if (v > 512) return 512;
			return v;
		endfunction

		// source position in Q.16 for one destination coordinate
		function longint unsigned src_pos(longint unsigned d, longint unsigned inv,
				longint unsigned size);
			longint unsigned t, pos, lim;
			t = (2 * d + 1) * inv;
			t = (t > 65536) ? t - 65536 : 0;
			pos = t >> 1;
			lim = (size - 1) << 16;
			return (pos > lim) ? lim : pos;
		endfunction

		function void note_beat(bit f, logic [12:0] rw, logic [12:0] cl,
				chan_t pb, chan_t pg, chan_t pr);
			longint unsigned pu, pv, r1, r2, c1, c2, fu, fv, wa, wb, wc, wd, acc;
			bit [23:0] p11, p12, p21, p22;
			chan_t res[3];
			pixel_t px;
			if (!f) begin
				if (rw < 512 && cl < 512)
					frame[rw * 512 + cl] = {pr, pg, pb};
				return;
			end
			pu = src_pos(rw, inv_rows, sat_size(height_reg));
			pv = src_pos(cl, inv_cols, sat_size(width_reg));
			r1 = pu >> 16; fu = pu & 16'hffff; r2 = r1 + (fu != 0);
			c1 = pv >> 16; fv = pv & 16'hffff; c2 = c1 + (fv != 0);
			wa = (65536 - fu) * (65536 - fv);
			wb = (65536 - fu) * fv;
			wc = fu * (65536 - fv);
			wd = fu * fv;
			p11 = frame[r1 * 512 + c1];
			p12 = frame[r1 * 512 + c2];
			p21 = frame[r2 * 512 + c1];
			p22 = frame[r2 * 512 + c2];
			for (int ch = 0; ch < 3; ch++) begin
				acc = wa * p11[ch*8 +: 8] + wb * p12[ch*8 +: 8]
					+ wc * p21[ch*8 +: 8] + wd * p22[ch*8 +: 8];
				res[ch] = acc[39:32];
			end
			px.b = res[0];
			px.g = color ? res[1] : 8'd0;
			px.r = color ? res[2] : 8'd0;
			pixel_q.push_back(px);
			computes++;
		endfunction

		function void check_beat(chan_t ob, chan_t og, chan_t orr);
			pixel_t px;
			if (pixel_q.size() == 0) begin
				$display("%t: unexpected pixel b=%0d g=%0d r=%0d", $realtime, ob, og, orr);
				fails++;
				return;
			end
			px = pixel_q.pop_front();
			if (px.b !== ob || px.g !== og || px.r !== orr) begin
				$display("%t: pixel mismatch expected b=%0d g=%0d r=%0d actual b=%0d g=%0d r=%0d",
					$realtime, px.b, px.g, px.r, ob, og, orr);
				fails++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n;
	logic        start, func;
	logic [12:0] row, col;
	chan_t       pix_b, pix_g, pix_r;
	logic        busy, done;
	chan_t       out_b, out_g, out_r;
	logic        psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	scaler_scoreboard sb = new();
	int gap_pct;

	bilinear_image_scaler i_dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk)
		if (arst_n && done)
			sb.check_beat(out_b, out_g, out_r);

	task automatic reg_write(int idx, logic [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= PADDR_W'(4 * idx); pwdata <= v;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
		psel <= 0; penable <= 0;
	endtask

	task automatic send_beat(bit f, logic [12:0] rw, logic [12:0] cl,
			chan_t pb, chan_t pg, chan_t pr);
		// each cycle the sender idles with probability gap_pct percent
		while ($urandom_range(99) < gap_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1; func <= f; row <= rw; col <= cl;
		pix_b <= pb; pix_g <= pg; pix_r <= pr;
		do @(posedge clk); while (busy);
		sb.note_beat(f, rw, cl, pb, pg, pr);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pixel_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_phase(logic [31:0] wr, logic [31:0] hr, logic [31:0] ir,
			logic [31:0] ic, logic [31:0] cm, int n_rand);
		int w, h, k;
		drain();
		reg_write(REG_SRC_WIDTH, wr);
		reg_write(REG_SRC_HEIGHT, hr);
		reg_write(REG_INV_ROWS, ir);
		reg_write(REG_INV_COLS, ic);
		reg_write(REG_COLOR_MODE, cm);
		w = sb.sat_size(wr & 32'h3ff);
		h = sb.sat_size(hr & 32'h3ff);
		// fill everything a compute can touch
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++)
				send_beat(0, r, c, $urandom, $urandom, $urandom);
		for (int i = 0; i < n_rand; i++) begin
			k = $urandom_range(99);
			if (k < 55)
				send_beat(1, $urandom_range(2 * h + 2), $urandom_range(2 * w + 2),
					$urandom, $urandom, $urandom);
			else if (k < 70)
				send_beat(1, $urandom, $urandom, $urandom, $urandom, $urandom);
			else if (k < 88)
				send_beat(0, $urandom_range(h - 1), $urandom_range(w - 1),
					$urandom, $urandom, $urandom);
			else if (k < 94 && h < 512)
				send_beat(0, $urandom_range(511, h), $urandom_range(511),
					$urandom, $urandom, $urandom);
			else
				send_beat(0, $urandom_range(8191, 512), $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		arst_n <= 0; start <= 0; func <= 0; row <= 0; col <= 0;
		pix_b <= 0; pix_g <= 0; pix_r <= 0;
		psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
		gap_pct = 37;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		run_phase(4, 3, 65536, 65536, 1, 0);
		// directed: corners, far destinations, stores off the frame store
		send_beat(1, 0, 0, 0, 0, 0);
		send_beat(1, 8191, 8191, 255, 255, 255);
		send_beat(1, 0, 8191, 0, 0, 0);
		send_beat(1, 8191, 0, 0, 0, 0);
		send_beat(0, 8191, 0, 255, 255, 255);
		send_beat(0, 0, 8191, 255, 255, 255);
		send_beat(0, 512, 512, 255, 255, 255);
		send_beat(0, 0, 0, 255, 255, 255);
		send_beat(0, 2, 3, 0, 0, 0);
		send_beat(0, 1, 1, 255, 0, 255);
		send_beat(1, 0, 0, 0, 0, 0);
		send_beat(1, 1, 1, 0, 0, 0);
		send_beat(1, 2, 3, 0, 0, 0);
		send_beat(1, 5, 7, 0, 0, 0);
		run_phase(0, 0, 0, 4096, 0, 50);
		gap_pct = 85;
		run_phase(1023, 1, 1048576, 2097151, 1, 60);
		run_phase(1, 60, 4096, 1048576, 0, 50);
		gap_pct = 0;
		run_phase(9, 6, 30000, 123457, 1, 60);
		run_phase(5, 7, 1048576, 4096, 0, 50);
		run_phase(13, 11, 47000, 71234, 1, 50);
		drain();

		$display("covered %0d destination pixels over seven register settings",
			sb.computes);
		$display("sizes from one to full width, scales from zero to the register maximum");
		if (sb.fails == 0)
			$display("bilinear_image_scaler_tb OK");
		else
			$display("bilinear_image_scaler_tb NOT OK");
		$finish;
	end

	initial begin
		#2ms;
		$display("bilinear_image_scaler_tb NOT OK");
		$finish;
	end
endmodule

// File: bilinear_image_scaler.f
src/bis_pkg.sv
src/bilinear_image_scaler.sv
dv/bilinear_image_scaler_tb.sv
